// ===== rtl/zbuffer_depth_test_shader_core_defines.svh =====
// assertion helpers for the checker file
// both expect clk_i and rst_ni in the enclosing scope
`ifndef ZBUFFER_DEPTH_TEST_SHADER_CORE_DEFINES_SVH
`define ZBUFFER_DEPTH_TEST_SHADER_CORE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define ZBDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ZBDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/zbdt_pkg.sv =====
package zbdt_pkg;

  localparam int X_BITS = 9;
  localparam int Y_BITS = 9;
  localparam int ADDR_W = X_BITS + Y_BITS;

  localparam int PIX_W     = 9;
  localparam int INT_W     = 9;
  localparam int DEPTH_W   = 48;
  localparam int SLOPE_W   = 32;
  localparam int COLOR_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int PX_PROD_W = SLOPE_W + X_BITS + 1;
  localparam int PY_PROD_W = SLOPE_W + Y_BITS + 1;
  localparam int SUM_W     = DEPTH_W + 2;
  localparam int SHADE_W   = CHAN_W + INT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [INT_W-1:0]          FULL_INTENSITY = 9'd256;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN      = {1'b1, {(DEPTH_W-1){1'b0}}};
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX      = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam logic [COLOR_W-1:0]        WHITE          = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0]        BASE_RESET     = 24'h77DD77;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_ORIGIN = 3'd0,
    CFG_SLOPE_X      = 3'd1,
    CFG_SLOPE_Y      = 3'd2,
    CFG_PLANE_VALID  = 3'd3,
    CFG_BASE_COLOR   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_FRAGMENT = 1'b0,
    OP_READ     = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic                        en;
    logic [ADDR_W-1:0]           addr;
    logic signed [DEPTH_W-1:0]   depth;
    logic [COLOR_W-1:0]          color;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

endpackage

// ===== rtl/zbdt_req_if.sv =====
interface zbdt_req_if;
  import zbdt_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic [INT_W-1:0] intensity;

  modport source (output valid, output opcode, output pixel_x, output pixel_y,
                  output intensity, input ready);
  modport sink   (input valid, input opcode, input pixel_x, input pixel_y,
                  input intensity, output ready);
endinterface

// ===== rtl/zbdt_rsp_if.sv =====
interface zbdt_rsp_if;
  import zbdt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      was_written;
  logic signed [DEPTH_W-1:0] depth_value;
  logic [COLOR_W-1:0]        color_value;

  modport source (output valid, output was_written, output depth_value,
                  output color_value, input ready);
  modport sink   (input valid, input was_written, input depth_value,
                  input color_value, output ready);
endinterface

// ===== rtl/zbdt_store.sv =====
module zbdt_store (
  input  logic                              clk_i,
  input  zbdt_pkg::store_wr_t               wr_i,
  input  zbdt_pkg::store_rd_t               rd_i,
  output logic signed [zbdt_pkg::DEPTH_W-1:0] rd_depth_o,
  output logic [zbdt_pkg::COLOR_W-1:0]      rd_color_o
);
  import zbdt_pkg::*;

  localparam int DEPTH_ENTRIES = 1 << ADDR_W;

  logic signed [DEPTH_W-1:0] depth_mem [DEPTH_ENTRIES];
  logic [COLOR_W-1:0]        color_mem [DEPTH_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      depth_mem[wr_i.addr] <= wr_i.depth;
    end
    if (rd_i.en) begin
      rd_depth_o <= depth_mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      color_mem[wr_i.addr] <= wr_i.color;
    end
    if (rd_i.en) begin
      rd_color_o <= color_mem[rd_i.addr];
    end
  end

endmodule

// ===== rtl/zbuffer_depth_test_shader_core.sv =====
// Z-buffer depth test and flat shader over a 2^(X_BITS+Y_BITS) entry depth and color store
// (512 x 512 pixels, 48 bit Q32.16 depth plus 24 bit RGB per pixel). A fragment request
// evaluates the configured plane at its pixel, saturates the depth to 48 bits and, when the
// plane is valid and the depth is strictly greater than the stored one, writes the depth and
// the base color scaled per channel by the intensity (clamped to 256). A read request
// returns the stored depth and color. Every request gives exactly one response. After reset
// the block sweeps the whole store once, one entry per cycle, to the most negative depth and
// white, during which requests are held off (configuration writes still land). Afterwards
// each request passes through accept and store read, multiply, sum and saturate, compare
// and write back; the store carries one read-modify-write at a time, so a new request is
// taken only once the last one is written back. The response sits in an output register, so
// the next request is accepted while the last response waits; the compare stage holds only
// if the previous response is still not taken. The user must write configuration only while
// no request is in flight; the block itself does not enforce it.
module zbuffer_depth_test_shader_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [zbdt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [zbdt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  zbdt_req_if.sink                            req_i,
  zbdt_rsp_if.source                          rsp_o
);
  import zbdt_pkg::*;

  // configuration registers
  logic signed [DEPTH_W-1:0] origin_q;
  logic signed [SLOPE_W-1:0] slope_x_q;
  logic signed [SLOPE_W-1:0] slope_y_q;
  logic                      plane_valid_q;
  logic [COLOR_W-1:0]        base_color_q;

  // sequencer
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              req_ready;
  logic              load_rsp;
  store_wr_t         store_wr;
  store_rd_t         store_rd;

  // request being worked on
  logic              op_q;
  logic [X_BITS-1:0] px_q;
  logic [Y_BITS-1:0] py_q;
  logic [INT_W-1:0]  inten_q;

  // datapath registers
  logic signed [PX_PROD_W-1:0] prod_x_q;
  logic signed [PY_PROD_W-1:0] prod_y_q;
  logic [COLOR_W-1:0]          shade_q;
  logic signed [DEPTH_W-1:0]   z_q;

  // store read data
  logic signed [DEPTH_W-1:0] rd_depth;
  logic [COLOR_W-1:0]        rd_color;

  // response register
  logic                      rsp_valid_q;
  logic                      rsp_written_q;
  logic signed [DEPTH_W-1:0] rsp_depth_q;
  logic [COLOR_W-1:0]        rsp_color_q;

  // request decode: low coordinate bits address the store, intensity clamps to full
  logic [PIX_W+X_BITS-1:0] px_ext;
  logic [PIX_W+Y_BITS-1:0] py_ext;
  logic [X_BITS-1:0]       req_px;
  logic [Y_BITS-1:0]       req_py;
  logic [INT_W-1:0]        req_inten;
  logic                    req_fire;

  assign px_ext    = {{X_BITS{1'b0}}, req_i.pixel_x};
  assign py_ext    = {{Y_BITS{1'b0}}, req_i.pixel_y};
  assign req_px    = px_ext[X_BITS-1:0];
  assign req_py    = py_ext[Y_BITS-1:0];
  assign req_inten = (req_i.intensity > FULL_INTENSITY) ? FULL_INTENSITY : req_i.intensity;
  assign req_fire  = req_i.valid && req_ready;

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q      <= '0;
      slope_x_q     <= '0;
      slope_y_q     <= '0;
      plane_valid_q <= 1'b0;
      base_color_q  <= BASE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEPTH_ORIGIN: origin_q      <= cfg_data_i[DEPTH_W-1:0];
        CFG_SLOPE_X:      slope_x_q     <= cfg_data_i[SLOPE_W-1:0];
        CFG_SLOPE_Y:      slope_y_q     <= cfg_data_i[SLOPE_W-1:0];
        CFG_PLANE_VALID:  plane_valid_q <= cfg_data_i[0];
        CFG_BASE_COLOR:   base_color_q  <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // compare stage: depth test against the stored entry
  logic                      pass;
  logic                      res_written;
  logic signed [DEPTH_W-1:0] res_depth;
  logic [COLOR_W-1:0]        res_color;

  always_comb begin
    pass        = 1'b0;
    res_written = 1'b0;
    res_depth   = rd_depth;
    res_color   = '0;
    if (opcode_e'(op_q) == OP_READ) begin
      res_color = rd_color;
    end else if (plane_valid_q) begin
      pass        = z_q > rd_depth;
      res_written = pass;
      res_depth   = z_q;
      res_color   = pass ? shade_q : '0;
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // next state, store port control
  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    req_ready      = 1'b0;
    load_rsp       = 1'b0;
    store_rd.en    = 1'b0;
    store_rd.addr  = {req_px, req_py};
    store_wr.en    = 1'b0;
    store_wr.addr  = {px_q, py_q};
    store_wr.depth = z_q;
    store_wr.color = shade_q;
    case (state_q)
      ST_CLEAR: begin
        // sweep every entry to its reset value
        store_wr.en    = 1'b1;
        store_wr.addr  = clr_q;
        store_wr.depth = DEPTH_MIN;
        store_wr.color = WHITE;
        clr_d          = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready   = 1'b1;
        store_rd.en = req_i.valid;
        if (req_i.valid) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // wait here until the response register is free, write exactly once
        if (!rsp_valid_q || rsp_o.ready) begin
          load_rsp    = 1'b1;
          store_wr.en = pass;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q    <= req_i.opcode;
      px_q    <= req_px;
      py_q    <= req_py;
      inten_q <= req_inten;
    end
  end

  // multiply stage: plane slopes times coordinates, channels times intensity
  logic signed [X_BITS:0] px_s;
  logic signed [Y_BITS:0] py_s;
  logic [SHADE_W-1:0]     shade_r, shade_g, shade_b;

  assign px_s    = {1'b0, px_q};
  assign py_s    = {1'b0, py_q};
  assign shade_r = SHADE_W'(base_color_q[3*CHAN_W-1:2*CHAN_W]) * SHADE_W'(inten_q);
  assign shade_g = SHADE_W'(base_color_q[2*CHAN_W-1:CHAN_W]) * SHADE_W'(inten_q);
  assign shade_b = SHADE_W'(base_color_q[CHAN_W-1:0]) * SHADE_W'(inten_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_x_q <= PX_PROD_W'(slope_x_q) * PX_PROD_W'(px_s);
      prod_y_q <= PY_PROD_W'(slope_y_q) * PY_PROD_W'(py_s);
      shade_q  <= {shade_r[CHAN_W +: CHAN_W], shade_g[CHAN_W +: CHAN_W],
                   shade_b[CHAN_W +: CHAN_W]};
    end
  end

  // sum stage with saturation to the 48 bit range
  logic signed [SUM_W-1:0] z_sum;
  logic                    z_ovf;

  assign z_sum = SUM_W'(origin_q) + SUM_W'(prod_x_q) + SUM_W'(prod_y_q);
  assign z_ovf = (z_sum[SUM_W-1:DEPTH_W-1] != '0) && (z_sum[SUM_W-1:DEPTH_W-1] != '1);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      if (z_ovf) begin
        z_q <= z_sum[SUM_W-1] ? DEPTH_MIN : DEPTH_MAX;
      end else begin
        z_q <= z_sum[DEPTH_W-1:0];
      end
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_rsp) begin
      rsp_written_q <= res_written;
      rsp_depth_q   <= res_depth;
      rsp_color_q   <= res_color;
    end
  end

  assign req_i.ready       = req_ready;
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.was_written = rsp_written_q;
  assign rsp_o.depth_value = rsp_depth_q;
  assign rsp_o.color_value = rsp_color_q;

  zbdt_store u_store (
    .clk_i      (clk_i),
    .wr_i       (store_wr),
    .rd_i       (store_rd),
    .rd_depth_o (rd_depth),
    .rd_color_o (rd_color)
  );

endmodule

// ===== rtl/zbdt_checker.sv =====
`include "zbuffer_depth_test_shader_core_defines.svh"

module zbdt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                req_valid_i,
  input logic                                req_ready_i,
  input logic                                rsp_valid_i,
  input logic                                rsp_ready_i,
  input logic                                rsp_written_i,
  input logic signed [zbdt_pkg::DEPTH_W-1:0] rsp_depth_i,
  input logic [zbdt_pkg::COLOR_W-1:0]        rsp_color_i
);
  import zbdt_pkg::*;

  logic req_fire;
  logic rsp_stall;

  assign req_fire  = req_valid_i && req_ready_i;
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;

  // one read-modify-write at a time: no request right behind another
  `ZBDT_ASSERT_NEXT(a_no_back_to_back, req_fire, !req_fire, "request accepted while busy")

  // a response needs the full store round trip
  `ZBDT_ASSERT_NEXT(a_rsp_latency, req_fire, !$rose(rsp_valid_i), "response too early")

  // a stalled response keeps its payload
  `ZBDT_ASSERT_NEXT(a_rsp_hold, rsp_stall,
                    rsp_valid_i && $stable(rsp_written_i) && $stable(rsp_depth_i)
                    && $stable(rsp_color_i), "stalled response changed")

  // a stored depth beat the cleared value, so it cannot be the minimum
  `ZBDT_ASSERT_NOW(a_written_depth, rsp_valid_i && rsp_written_i, rsp_depth_i != DEPTH_MIN,
                   "written fragment carries minimum depth")

endmodule

bind zbuffer_depth_test_shader_core zbdt_checker u_zbdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_written_i (rsp_o.was_written),
  .rsp_depth_i   (rsp_o.depth_value),
  .rsp_color_i   (rsp_o.color_value)
);

// ===== tb/zbuffer_depth_test_shader_core_test.sv =====
`timescale 1ns / 100ps

module zbuffer_depth_test_shader_core_test;
  import zbdt_pkg::*;

  // generous cap: the post-reset store sweep alone covers all 2^18 entries
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned BATCH_ITEMS    = 40;
  localparam int unsigned HOT_PIXELS     = 8;
  localparam int unsigned DRAIN_CYCLES   = 16;
  // first index past the last real register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd5;

  // one response as the block should return it
  typedef struct packed {
    logic                      was_written;
    logic signed [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0]        color;
  } pixel_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  zbdt_req_if req_if ();
  zbdt_rsp_if rsp_if ();

  zbuffer_depth_test_shader_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the plane and surface registers, reset values
  logic signed [DEPTH_W-1:0] plane_origin  = '0;
  logic signed [SLOPE_W-1:0] plane_slope_x = '0;
  logic signed [SLOPE_W-1:0] plane_slope_y = '0;
  logic                      plane_enabled = 1'b0;
  logic [COLOR_W-1:0]        surface_color = BASE_RESET;

  // shadow z-buffer, entries missing here still hold the cleared values
  logic signed [DEPTH_W-1:0] zbuf_depth [bit [ADDR_W-1:0]];
  logic [COLOR_W-1:0]        zbuf_color [bit [ADDR_W-1:0]];

  // responses owed by the block, oldest first
  pixel_result_t pending_pixels [$];

  int unsigned mismatch_count    = 0;
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned hold_off_cycles   = 0;

  logic [PIX_W-1:0] hot_x [HOT_PIXELS];
  logic [PIX_W-1:0] hot_y [HOT_PIXELS];

  // depth test, shading and store update for one accepted request
  function automatic pixel_result_t predict_pixel(opcode_e op, logic [PIX_W-1:0] x,
                                                  logic [PIX_W-1:0] y,
                                                  logic [INT_W-1:0] inten);
    pixel_result_t             res;
    logic [ADDR_W-1:0]         addr;
    logic signed [DEPTH_W-1:0] stored;
    longint                    z;
    int unsigned               level;

    addr   = {x[X_BITS-1:0], y[Y_BITS-1:0]};
    stored = zbuf_depth.exists(addr) ? zbuf_depth[addr] : DEPTH_MIN;
    res.was_written = 1'b0;
    res.depth       = stored;
    res.color       = '0;
    if (op == OP_READ) begin
      res.color = zbuf_color.exists(addr) ? zbuf_color[addr] : WHITE;
    end else if (plane_enabled) begin
      // plane evaluation in 64 bits, then clamp to the 48 bit range
      z = longint'(plane_origin) + longint'(plane_slope_x) * longint'(x)
        + longint'(plane_slope_y) * longint'(y);
      if (z > longint'(DEPTH_MAX)) z = longint'(DEPTH_MAX);
      if (z < longint'(DEPTH_MIN)) z = longint'(DEPTH_MIN);
      res.depth = z[DEPTH_W-1:0];
      // strictly closer wins, ties keep the stored pixel
      if (z > longint'(stored)) begin
        level = (inten > FULL_INTENSITY) ? FULL_INTENSITY : inten;
        for (int c = 0; c < 3; c++)
          res.color[c*CHAN_W +: CHAN_W] = (surface_color[c*CHAN_W +: CHAN_W] * level) >> 8;
        res.was_written  = 1'b1;
        zbuf_depth[addr] = res.depth;
        zbuf_color[addr] = res.color;
      end
    end
    return res;
  endfunction

  // append one owed response at the young end of the queue
  function automatic void owe_result(pixel_result_t res);
    pending_pixels = {pending_pixels, res};
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // register write, only ever issued with no request in flight
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DEPTH_ORIGIN: plane_origin  = data[DEPTH_W-1:0];
      CFG_SLOPE_X:      plane_slope_x = data[SLOPE_W-1:0];
      CFG_SLOPE_Y:      plane_slope_y = data[SLOPE_W-1:0];
      CFG_PLANE_VALID:  plane_enabled = data[0];
      CFG_BASE_COLOR:   surface_color = data[COLOR_W-1:0];
      default: ;
    endcase
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // one request: random gap first, then hold until accepted
  task automatic send_pixel(opcode_e op, logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                            logic [INT_W-1:0] inten);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.opcode    <= op;
    req_if.pixel_x   <= x;
    req_if.pixel_y   <= y;
    req_if.intensity <= inten;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // mostly a small set of pixels so fragments fight over them and reads see results
  task automatic send_random_item();
    opcode_e          op;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [INT_W-1:0] inten;
    int unsigned      k;

    op = ($urandom_range(3) == 0) ? OP_READ : OP_FRAGMENT;
    if ($urandom_range(9) < 7) begin
      k = $urandom_range(HOT_PIXELS - 1);
      x = hot_x[k];
      y = hot_y[k];
    end else begin
      x = PIX_W'($urandom_range(2**PIX_W - 1));
      y = PIX_W'($urandom_range(2**PIX_W - 1));
    end
    // half within the legal shading range, half anywhere incl. over-bright
    if ($urandom_range(1))
      inten = INT_W'($urandom_range(FULL_INTENSITY));
    else
      inten = INT_W'($urandom_range(2**INT_W - 1));
    send_pixel(op, x, y, inten);
  endtask

  // drop valid and wait until every owed response has come back
  task automatic drain_requests();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_pixels.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [SLOPE_W-1:0] random_slope();
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return SLOPE_W'($urandom_range(20'hF_FFFF)) - 32'h0008_0000;
    endcase
  endfunction

  // reset contents: cleared store, plane disabled
  task automatic test_reset_state();
    send_pixel(OP_READ, '0, '0, '0);
    send_pixel(OP_READ, '1, '1, '1);
    // invalid plane hands back the stored depth and no color
    send_pixel(OP_FRAGMENT, '0, '1, FULL_INTENSITY);
    drain_requests();
  endtask

  // simple plane, depth test outcomes and per-channel shading
  task automatic test_depth_shading();
    cfg_write(CFG_DEPTH_ORIGIN, 48'h0000_0001_0000);
    // upper data bits above the slope width must be dropped
    cfg_write(CFG_SLOPE_X, {16'hDEAD, 32'h0001_0000});
    cfg_write(CFG_SLOPE_Y, {16'h5A5A, 32'hFFFF_0000});
    cfg_write(CFG_BASE_COLOR, {24'hC3C3C3, 24'hFFFFFF});
    cfg_write(CFG_PLANE_VALID, 48'hFFFF_FFFF_FFFF);
    send_pixel(OP_FRAGMENT, 9'd5, 9'd3, FULL_INTENSITY);
    // same depth again: a tie must not write
    send_pixel(OP_FRAGMENT, 9'd5, 9'd3, FULL_INTENSITY);
    // over-bright clamps to full, zero gives black, half halves each channel
    send_pixel(OP_FRAGMENT, 9'd6, 9'd3, 9'd511);
    send_pixel(OP_FRAGMENT, 9'd7, 9'd3, 9'd0);
    send_pixel(OP_FRAGMENT, 9'd8, 9'd3, 9'd128);
    send_pixel(OP_READ, 9'd5, 9'd3, 9'd0);
    // negative depth still beats the cleared store
    send_pixel(OP_FRAGMENT, 9'd0, 9'd511, 9'd200);
    drain_requests();
  endtask

  // depth clamping at both ends, ignored registers, plane disable
  task automatic test_saturation();
    cfg_write(CFG_DEPTH_ORIGIN, DEPTH_MAX);
    cfg_write(CFG_SLOPE_X, {16'h0000, 32'h7FFF_FFFF});
    cfg_write(CFG_SLOPE_Y, {16'hFFFF, 32'h7FFF_FFFF});
    cfg_write(CFG_BASE_COLOR, 48'h0000_0001_80FE);
    send_pixel(OP_FRAGMENT, '1, '1, FULL_INTENSITY);
    send_pixel(OP_FRAGMENT, '1, '1, FULL_INTENSITY);
    send_pixel(OP_READ, '1, '1, '0);
    drain_requests();
    cfg_write(CFG_DEPTH_ORIGIN, DEPTH_MIN);
    cfg_write(CFG_SLOPE_X, 48'h0000_8000_0000);
    cfg_write(CFG_SLOPE_Y, 48'hFFFF_8000_0000);
    // clamped to the floor, equal to the cleared store, so no write
    send_pixel(OP_FRAGMENT, '1, '0, 9'd100);
    send_pixel(OP_FRAGMENT, '0, '0, FULL_INTENSITY);
    drain_requests();
    // writes past the last register land nowhere
    for (int i = CFG_IDX_UNUSED; i < 2**CFG_IDX_W; i++)
      cfg_write(i[CFG_IDX_W-1:0], '1);
    cfg_write(CFG_PLANE_VALID, 48'hFFFF_FFFF_FFFE);
    send_pixel(OP_FRAGMENT, 9'd5, 9'd3, FULL_INTENSITY);
    send_pixel(OP_FRAGMENT, '0, '0, 9'd511);
    drain_requests();
    cfg_write(CFG_DEPTH_ORIGIN, '0);
    cfg_write(CFG_SLOPE_X, '0);
    cfg_write(CFG_SLOPE_Y, '0);
    cfg_write(CFG_PLANE_VALID, 48'h0000_0000_0001);
    // base color must have survived the ignored writes
    send_pixel(OP_FRAGMENT, 9'd1, 9'd1, 9'd300);
    drain_requests();
  endtask

  // output held off long enough for the pipeline to back up into the input
  task automatic test_backpressure();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_off_cycles   = 300;
    repeat (12) send_random_item();
    drain_requests();
  endtask

  // batches of random traffic, each under a fresh random plane
  task automatic test_random_traffic(int unsigned n_items, int unsigned send_pct,
                                     int unsigned recv_pct);
    int unsigned sent;
    longint      origin_val;

    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    hot_x[0] = '0;
    hot_y[0] = '0;
    hot_x[1] = '1;
    hot_y[1] = '1;
    for (int k = 2; k < HOT_PIXELS; k++) begin
      hot_x[k] = PIX_W'($urandom_range(2**PIX_W - 1));
      hot_y[k] = PIX_W'($urandom_range(2**PIX_W - 1));
    end
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(3))
        0:       origin_val = longint'(DEPTH_MAX);
        1:       origin_val = longint'(DEPTH_MIN);
        2:       origin_val = longint'({$urandom, $urandom});
        default: origin_val = longint'($urandom_range(32'h01FF_FFFF)) - 64'sd16777216;
      endcase
      cfg_write(CFG_DEPTH_ORIGIN, origin_val[DEPTH_W-1:0]);
      cfg_write(CFG_SLOPE_X, {16'($urandom), random_slope()});
      cfg_write(CFG_SLOPE_Y, {16'($urandom), random_slope()});
      cfg_write(CFG_PLANE_VALID, {47'($urandom), ($urandom_range(9) < 8)});
      cfg_write(CFG_BASE_COLOR, {24'($urandom), 24'($urandom)});
      if ($urandom_range(3) == 0) begin
        for (int i = CFG_IDX_UNUSED; i < 2**CFG_IDX_W; i++)
          cfg_write(i[CFG_IDX_W-1:0], {16'($urandom), $urandom});
      end
      repeat (BATCH_ITEMS) send_random_item();
      sent += BATCH_ITEMS;
      drain_requests();
    end
  endtask

  // predict at request acceptance, in acceptance order
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      owe_result(predict_pixel(opcode_e'(req_if.opcode), req_if.pixel_x,
                               req_if.pixel_y, req_if.intensity));
  end

  // each accepted response against the oldest owed one
  always @(posedge clk_i) begin : check_responses
    pixel_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = pending_pixels.pop_front();
        if (rsp_if.was_written !== want.was_written)
          report_mismatch($sformatf("was_written got %b want %b",
                                    rsp_if.was_written, want.was_written));
        if (rsp_if.depth_value !== want.depth)
          report_mismatch($sformatf("depth_value got %h want %h",
                                    rsp_if.depth_value, want.depth));
        if (rsp_if.color_value !== want.color)
          report_mismatch($sformatf("color_value got %h want %h",
                                    rsp_if.color_value, want.color));
      end
    end
  end

  // response side: long hold-off when asked, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_off_cycles != 0) begin
      rsp_if.ready <= 1'b0;
      hold_off_cycles--;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    req_if.valid     = 1'b0;
    req_if.opcode    = OP_FRAGMENT;
    req_if.pixel_x   = '0;
    req_if.pixel_y   = '0;
    req_if.intensity = '0;
    rsp_if.ready     = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender idles lightly, receiver heavily
    sender_idle_pct   = 34;
    receiver_idle_pct = 73;
    // requests stall here until the store sweep after reset is done
    test_reset_state();
    test_depth_shading();
    test_saturation();
    test_random_traffic(640, 34, 73);
    // then the other way round
    test_random_traffic(640, 73, 34);
    test_backpressure();
    // back to back on both sides
    test_random_traffic(640, 0, 0);

    drain_requests();
    // room for any stray extra response to show up
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/zbdt_pkg.sv
rtl/zbdt_req_if.sv
rtl/zbdt_rsp_if.sv
rtl/zbdt_store.sv
rtl/zbuffer_depth_test_shader_core.sv
rtl/zbdt_checker.sv
tb/zbuffer_depth_test_shader_core_test.sv
